/* rtl/atr_pkg.sv */
// ----------------------------------------------------------------------------
// atr_pkg: shared types and constants of the argmin tournament tree
// Tree geometry, node type, controller states, command/status groups and
// helper functions used by the controller, datapath and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package atr_pkg;

    // Tree geometry
    localparam int LEAVES     = 1024;
    localparam int VALUE_BITS = 16;
    localparam int LEVELS     = (LEAVES > 1) ? $clog2(LEAVES) : 1;
    localparam int TREE_N     = 1 << LEVELS;
    localparam int NODES      = 2 * TREE_N;
    localparam int ADDR_W     = LEVELS + 1;
    localparam int IDX_W      = LEVELS;

    // Fixed widths of the request and result fields
    localparam int SLOT_W      = 10;
    localparam int IN_VALUE_W  = 16;
    localparam int OUT_SLOT_W  = 10;
    localparam int OUT_VALUE_W = 16;

    // One tree node: winner index and its value
    typedef struct packed {
        logic [IDX_W-1:0]      idx;
        logic [VALUE_BITS-1:0] val;
    } node_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CLIMB,
        ST_EMIT
    } atr_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_step;   // write reset contents of one node
        logic leaf_write;   // write the accepted request into its leaf
        logic climb_step;   // recompute one parent on the path
        logic emit_root;    // present the current root unchanged
    } atr_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;   // clearing pass is at its last node
        logic at_top;       // next climb step writes the root
        logic in_range;     // requested slot is a real leaf
        logic out_free;     // result register can take a new result
    } atr_stat_t;

    // Smaller value wins; on a tie the right child wins
    function automatic node_t pick(node_t l, node_t r);
        return (l.val < r.val) ? l : r;
    endfunction

    // Reset contents of a node: sentinel value, rightmost leaf of its subtree
    function automatic node_t reset_node(logic [ADDR_W-1:0] a);
        logic [31:0] w;
        node_t       r;
        r.idx = '0;
        r.val = '1;
        for (int i = 0; i <= LEVELS; i++) begin
            if ((32'(a) >> (LEVELS - i)) == 32'd1) begin
                w = (32'(a) << i) | ((32'd1 << i) - 32'd1);
                r.idx = w[IDX_W-1:0];
            end
        end
        return r;
    endfunction

    // Drop request value bits above VALUE_BITS
    function automatic logic [VALUE_BITS-1:0] in_value(logic [IN_VALUE_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[VALUE_BITS-1:0];
    endfunction

endpackage

/* rtl/atr_if.sv */
// ----------------------------------------------------------------------------
// atr_if: request and result channels of the argmin tournament tree
// Valid/ready channels; a request or result moves when both are high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface atr_in_if;
    logic                          valid;
    logic                          ready;
    logic [atr_pkg::SLOT_W-1:0]    slot;
    logic [atr_pkg::IN_VALUE_W-1:0] new_value;

    modport source (output valid, output slot, output new_value, input ready);
    modport sink   (input valid, input slot, input new_value, output ready);
endinterface

interface atr_out_if;
    logic                            valid;
    logic                            ready;
    logic [atr_pkg::OUT_SLOT_W-1:0]  min_slot;
    logic [atr_pkg::OUT_VALUE_W-1:0] min_value;

    modport source (output valid, output min_slot, output min_value, input ready);
    modport sink   (input valid, input min_slot, input min_value, output ready);
endinterface

/* rtl/argmin_tournament_tree.sv */
// ----------------------------------------------------------------------------
// argmin_tournament_tree: point-update argmin over a binary tournament tree
// Each request writes one slot and returns the slot and value of the minimum.
// ----------------------------------------------------------------------------
// Path: the leaf write, then one parent per tree level (10 levels) up to
//   the root, through the single read/compare/write node memory.
// Requests are taken one at a time, each after the previous result is
//   loaded; a slot outside the tree answers the current root instead.
// Reset: after rst_n a clearing pass writes all 2047 nodes, one per cycle;
//   no request is taken until it ends.
`timescale 1ns / 1ps

module argmin_tournament_tree (
    input  logic       clk,
    input  logic       rst_n,
    atr_in_if.sink     items,
    atr_out_if.source  results
);

    atr_pkg::atr_cmd_t  cmd;
    atr_pkg::atr_stat_t stat;

    // Sequencer
    atr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (items.ready)
    );

    // Node store and compare path
    atr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .slot      (items.slot),
        .new_value (items.new_value),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (results.ready),
        .out_valid (results.valid),
        .min_slot  (results.min_slot),
        .min_value (results.min_value)
    );

endmodule

/* rtl/atr_ctrl.sv */
// ----------------------------------------------------------------------------
// atr_ctrl: sequencer of the argmin tournament tree
// Runs the clearing pass after reset, accepts one request at a time and
// steps the datapath up the tree one level per cycle, the root step waiting for a free result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  atr_pkg::atr_stat_t stat,
    output atr_pkg::atr_cmd_t  cmd,
    output logic              in_ready
);

    atr_pkg::atr_state_t state_reg;
    atr_pkg::atr_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= atr_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            atr_pkg::ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = atr_pkg::ST_IDLE;
                end
            end
            atr_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stat.in_range ? atr_pkg::ST_CLIMB : atr_pkg::ST_EMIT;
                end
            end
            atr_pkg::ST_CLIMB:
            begin
                if (stat.at_top && stat.out_free)
                begin
                    state_next = atr_pkg::ST_IDLE;
                end
            end
            atr_pkg::ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = atr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = atr_pkg::ST_CLEAR;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            atr_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            atr_pkg::ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.leaf_write = in_valid && stat.in_range;
            end
            atr_pkg::ST_CLIMB:
            begin
                // hold the root write until the result register is free
                cmd.climb_step = !stat.at_top || stat.out_free;
            end
            atr_pkg::ST_EMIT:
            begin
                cmd.emit_root = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/atr_datapath.sv */
// ----------------------------------------------------------------------------
// atr_datapath: node store and compare path of the argmin tournament tree
// Node memory with one write and one registered read port, the climbing
// path registers, the root copy and the result valid flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module atr_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [atr_pkg::SLOT_W-1:0]        slot,
    input  logic [atr_pkg::IN_VALUE_W-1:0]    new_value,
    input  atr_pkg::atr_cmd_t                 cmd,
    output atr_pkg::atr_stat_t                stat,
    input  logic                              out_ready,
    output logic                              out_valid,
    output logic [atr_pkg::OUT_SLOT_W-1:0]    min_slot,
    output logic [atr_pkg::OUT_VALUE_W-1:0]   min_value
);

    // Node store
    atr_pkg::node_t mem [atr_pkg::NODES];

    logic [atr_pkg::ADDR_W-1:0] clr_addr_reg;
    logic [atr_pkg::ADDR_W-1:0] clr_addr_next;
    logic [atr_pkg::ADDR_W-1:0] cur_addr_reg;
    logic [atr_pkg::ADDR_W-1:0] cur_addr_next;
    atr_pkg::node_t             cur_node_reg;
    atr_pkg::node_t             cur_node_next;
    atr_pkg::node_t             rd_data_reg;
    atr_pkg::node_t             root_reg;
    atr_pkg::node_t             root_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;

    logic                       we;
    logic [atr_pkg::ADDR_W-1:0] waddr;
    atr_pkg::node_t             wdata;
    logic [atr_pkg::ADDR_W-1:0] raddr;

    logic [atr_pkg::ADDR_W-1:0] leaf_addr;
    atr_pkg::node_t             leaf_node;
    logic [atr_pkg::ADDR_W-1:0] parent_addr;
    atr_pkg::node_t             win;
    logic                       load_out;
    logic [31:0]                root_idx_w;
    logic [31:0]                root_val_w;

    // Leaf of the request and winner of the current level
    always_comb
    begin
        leaf_addr     = atr_pkg::ADDR_W'(atr_pkg::TREE_N + 32'(slot));
        leaf_node.idx = atr_pkg::IDX_W'(slot);
        leaf_node.val = atr_pkg::in_value(new_value);
        parent_addr   = cur_addr_reg >> 1;
        if (cur_addr_reg[0])
        begin
            win = atr_pkg::pick(rd_data_reg, cur_node_reg);
        end
        else
        begin
            win = atr_pkg::pick(cur_node_reg, rd_data_reg);
        end
    end

    // Status
    always_comb
    begin
        stat.clear_last = (clr_addr_reg == atr_pkg::ADDR_W'(atr_pkg::NODES - 1));
        stat.at_top     = (parent_addr == atr_pkg::ADDR_W'(1));
        stat.in_range   = (32'(slot) < atr_pkg::LEAVES);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // Memory port selection and register next values
    always_comb
    begin
        we            = 1'b0;
        waddr         = cur_addr_reg;
        wdata         = cur_node_reg;
        // keep the sibling in the read register while the root write waits
        raddr         = cur_addr_reg ^ atr_pkg::ADDR_W'(1);
        clr_addr_next = clr_addr_reg;
        cur_addr_next = cur_addr_reg;
        cur_node_next = cur_node_reg;
        root_next     = root_reg;
        load_out      = 1'b0;

        if (cmd.clear_step)
        begin
            we            = 1'b1;
            waddr         = clr_addr_reg;
            wdata         = atr_pkg::reset_node(clr_addr_reg);
            clr_addr_next = clr_addr_reg + atr_pkg::ADDR_W'(1);
            if (clr_addr_reg == atr_pkg::ADDR_W'(1))
            begin
                root_next = atr_pkg::reset_node(clr_addr_reg);
            end
        end
        else if (cmd.leaf_write)
        begin
            we            = 1'b1;
            waddr         = leaf_addr;
            wdata         = leaf_node;
            raddr         = leaf_addr ^ atr_pkg::ADDR_W'(1);
            cur_addr_next = leaf_addr;
            cur_node_next = leaf_node;
        end
        else if (cmd.climb_step)
        begin
            we            = 1'b1;
            waddr         = parent_addr;
            wdata         = win;
            raddr         = parent_addr ^ atr_pkg::ADDR_W'(1);
            cur_addr_next = parent_addr;
            cur_node_next = win;
            if (stat.at_top)
            begin
                root_next = win;
                load_out  = 1'b1;
            end
        end
        else if (cmd.emit_root)
        begin
            load_out = 1'b1;
        end

        // result flag: set on a new result, cleared when taken
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Node memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= atr_pkg::ADDR_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Path and root registers
    always_ff @(posedge clk)
    begin
        cur_addr_reg <= cur_addr_next;
        cur_node_reg <= cur_node_next;
        root_reg     <= root_next;
    end

    // Result payload is the root copy; it holds while the result waits
    always_comb
    begin
        root_idx_w = 32'(root_reg.idx);
        root_val_w = 32'(root_reg.val);
        out_valid  = out_valid_reg;
        min_slot   = root_idx_w[atr_pkg::OUT_SLOT_W-1:0];
        min_value  = root_val_w[atr_pkg::OUT_VALUE_W-1:0];
    end

endmodule

/* sim/tb_argmin_tournament_tree.sv */
// ----------------------------------------------------------------------------
// tb_argmin_tournament_tree: self-checking bench for the argmin tournament tree
// Drives slot updates over the request channel and tracks its own copy of the
// tournament tree. Every update predicts the new root (slot and value of the
// minimum, ties toward the higher slot). Each returned result is checked
// against the oldest predicted root. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_argmin_tournament_tree;

    import atr_pkg::*;

    localparam int unsigned RANDOM_UPDATES = 950;
    localparam int unsigned QUIET_LIMIT    = 8000;  // longer than the clearing pass
    localparam int unsigned LONG_HOLD      = 400;
    localparam int unsigned HOLD_AFTER     = 300;
    localparam int unsigned TAIL_CYCLES    = 30;

    localparam logic [IN_VALUE_W-1:0] SENTINEL = '1;

    typedef struct {
        logic [OUT_SLOT_W-1:0]  min_slot;
        logic [OUT_VALUE_W-1:0] min_value;
    } root_t;

    // Own copy of the tree plus the queue of roots still owed by the block
    class min_tracker;
        node_t       tree [NODES];
        root_t       roots_due [$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
            tree[0] = '0;
            for (int i = 0; i < TREE_N; i++)
            begin
                tree[TREE_N + i].idx = IDX_W'(i);
                tree[TREE_N + i].val = '1;
            end
            for (int i = TREE_N - 1; i > 0; i--)
                tree[i] = winner(tree[2 * i], tree[2 * i + 1]);
        endfunction

        // Right child wins unless the left one is strictly smaller
        function node_t winner(node_t l, node_t r);
            if (r.val <= l.val)
                return r;
            return l;
        endfunction

        // Accepted update: rewrite the leaf, replay its path, queue the root
        function void apply_update(logic [SLOT_W-1:0] slot, logic [IN_VALUE_W-1:0] value);
            int unsigned p;
            root_t       r;
            if (slot < LEAVES)
            begin
                p = TREE_N + slot;
                tree[p].idx = IDX_W'(slot);
                tree[p].val = VALUE_BITS'(value);
                while (p > 1)
                begin
                    p = p >> 1;
                    tree[p] = winner(tree[2 * p], tree[2 * p + 1]);
                end
            end
            r.min_slot  = OUT_SLOT_W'(tree[1].idx);
            r.min_value = OUT_VALUE_W'(tree[1].val);
            roots_due = {roots_due, r};
        endfunction

        function void report(string what, logic [31:0] exp_v, logic [31:0] act_v);
            mismatches++;
            $display("[%0t] %s mismatch: expected %0d, got %0d", $time, what, exp_v, act_v);
        endfunction

        // Accepted result: compare with the oldest predicted root
        function void check_root(logic [OUT_SLOT_W-1:0] slot, logic [OUT_VALUE_W-1:0] value);
            root_t r;
            if (roots_due.size() == 0)
            begin
                mismatches++;
                $display("[%0t] unexpected result: expected none, got slot %0d value %0d",
                         $time, slot, value);
                return;
            end
            r = roots_due.pop_front();
            if (slot !== r.min_slot)
                report("min_slot", 32'(r.min_slot), 32'(slot));
            if (value !== r.min_value)
                report("min_value", 32'(r.min_value), 32'(value));
        endfunction

        function int unsigned outstanding();
            return roots_due.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    min_tracker  book;
    int unsigned results_seen;

    atr_in_if  in_ch ();
    atr_out_if out_ch ();

    argmin_tournament_tree u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (in_ch),
        .results (out_ch)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned rand_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    // Offer one request and hold it until the block takes it
    task automatic send_update(input logic [SLOT_W-1:0] slot, input logic [IN_VALUE_W-1:0] value);
        in_ch.valid     <= 1'b1;
        in_ch.slot      <= slot;
        in_ch.new_value <= value;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        book.apply_update(slot, value);
    endtask

    task automatic sender_gap(input int unsigned cycles);
        if (cycles > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Drop valid and wait until the block has answered everything
    task automatic drain_block();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (book.outstanding() != 0)
            @(posedge clk);
    endtask

    // Result monitor
    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
        begin
            book.check_root(out_ch.min_slot, out_ch.min_value);
            results_seen <= results_seen + 1;
        end
    end

    // Receiver: random stalls, calm stretches, one long hold-off
    initial
    begin
        int unsigned stall_left;
        int unsigned hold_left;
        int unsigned calm_left;
        bit          held;
        stall_left = 0;
        hold_left  = 0;
        calm_left  = 0;
        held       = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held      = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 19) == 0)
                    calm_left = $urandom_range(30, 120);
                else
                    stall_left = rand_gap();
            end
            @(posedge clk);
        end
    end

    // Watchdog: ends the run after too long without any transfer
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Reset, directed updates, random updates, drain and verdict
    initial
    begin
        logic [SLOT_W-1:0]     d_slot [];
        logic [IN_VALUE_W-1:0] d_value [];
        logic [SLOT_W-1:0]     slot;
        logic [IN_VALUE_W-1:0] value;
        int unsigned           pick_kind;
        bit                    calm;

        book         = new();
        results_seen = 0;
        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.slot      <= '0;
        in_ch.new_value <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: sentinel rewrite, ties in both directions, extremes,
        // raising the current minimum, alternating bit patterns, clean-up
        d_slot  = '{10'd5, 10'd0, 10'd1023, 10'd512, 10'd511, 10'd513, 10'd513,
                    10'd512, 10'd511, 10'd0, 10'd1023, 10'd341, 10'd682, 10'd1023,
                    10'd682, 10'd170, 10'd853, 10'd0, 10'd341, 10'd511, 10'd682,
                    10'd170, 10'd853};
        d_value = '{SENTINEL, 16'hFFFE, 16'hFFFE, 16'd100, 16'd100, 16'd100, SENTINEL,
                    SENTINEL, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, SENTINEL,
                    16'd1, 16'h5555, 16'hAAAA, SENTINEL, SENTINEL, SENTINEL, SENTINEL,
                    SENTINEL, SENTINEL};
        foreach (d_slot[i])
        begin
            send_update(d_slot[i], d_value[i]);
            sender_gap(rand_gap());
        end
        drain_block();

        // Random updates: mixed slots and values, tie clusters, minimum churn
        calm = 1'b0;
        for (int n = 0; n < RANDOM_UPDATES; n++)
        begin
            if (n % 50 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_UPDATES / 2)
                drain_block();
            pick_kind = $urandom_range(0, 99);
            if (pick_kind < 35)
            begin
                slot  = SLOT_W'($urandom_range(0, LEAVES - 1));
                value = IN_VALUE_W'($urandom_range(0, 65535));
            end
            else if (pick_kind < 60)
            begin
                // Hot slots with a narrow value range: many ties
                slot  = ($urandom_range(0, 1) == 0) ? SLOT_W'($urandom_range(0, 15))
                                                    : SLOT_W'($urandom_range(1008, 1023));
                value = IN_VALUE_W'($urandom_range(0, 7));
            end
            else if (pick_kind < 80)
            begin
                // Raise or erase the current minimum so the root can move
                slot  = book.tree[1].idx;
                value = ($urandom_range(0, 1) == 0)
                        ? SENTINEL
                        : IN_VALUE_W'($urandom_range(book.tree[1].val, 65535));
            end
            else if (pick_kind < 90)
            begin
                slot = SLOT_W'($urandom_range(0, LEAVES - 1));
                case ($urandom_range(0, 3))
                    0: value = 16'd0;
                    1: value = 16'd1;
                    2: value = 16'hFFFE;
                    default: value = SENTINEL;
                endcase
            end
            else
            begin
                slot  = ($urandom_range(0, 1) == 0) ? 10'd0 : 10'd1023;
                value = IN_VALUE_W'($urandom_range(0, 65535));
            end
            send_update(slot, value);
            sender_gap(calm ? 0 : rand_gap());
        end

        drain_block();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (book.mismatches == 0 && book.outstanding() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
